/* hdl/tdpt_pkg.sv */
// Shared types, step and condition codes, and microcode table of the prime test unit.
package tdpt_pkg;

    // Step counter and condition select widths
    localparam int STEP_W = 4;
    localparam int COND_W = 4;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [COND_W-1:0] cond_t;

    // Jump conditions
    localparam cond_t COND_NEVER    = 4'd0;
    localparam cond_t COND_ALWAYS   = 4'd1;
    localparam cond_t COND_NO_INPUT = 4'd2;
    localparam cond_t COND_N_LT2    = 4'd3;
    localparam cond_t COND_N_EQ2    = 4'd4;
    localparam cond_t COND_N_EVEN   = 4'd5;
    localparam cond_t COND_DIV_BUSY = 4'd6;
    localparam cond_t COND_D_GT_Q   = 4'd7;
    localparam cond_t COND_REM_ZERO = 4'd8;
    localparam cond_t COND_OUT_FULL = 4'd9;

    // Program steps
    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_LT2   = 4'd1;
    localparam step_t STEP_EQ2   = 4'd2;
    localparam step_t STEP_EVEN  = 4'd3;
    localparam step_t STEP_DIV   = 4'd4;
    localparam step_t STEP_WAIT  = 4'd5;
    localparam step_t STEP_BOUND = 4'd6;
    localparam step_t STEP_REM   = 4'd7;
    localparam step_t STEP_NEXT  = 4'd8;
    localparam step_t STEP_EMIT  = 4'd9;
    localparam step_t STEP_DONE  = 4'd10;

    // One control word per step
    typedef struct packed {
        logic  accept;     // input channel ready
        logic  div_start;  // launch a remainder computation
        logic  d_inc;      // advance to the next odd divisor
        logic  res_we;     // write the verdict register
        logic  res_val;    // verdict value
        logic  emit;       // move verdict to the output register
        cond_t cond;       // jump condition
        step_t target;     // jump target
    } ctrl_word_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic no_input;
        logic n_lt2;
        logic n_eq2;
        logic n_even;
        logic div_busy;
        logic d_gt_q;
        logic rem_zero;
        logic out_full;
    } flags_t;

    // Microcode: if the condition holds jump to target, else fall through
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        w = '0;
        case (pc)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_IDLE;
            end
            STEP_LT2: begin
                w.res_we  = 1'b1;
                w.res_val = 1'b0;
                w.cond    = COND_N_LT2;
                w.target  = STEP_EMIT;
            end
            STEP_EQ2: begin
                w.res_we  = 1'b1;
                w.res_val = 1'b1;
                w.cond    = COND_N_EQ2;
                w.target  = STEP_EMIT;
            end
            STEP_EVEN: begin
                w.res_we  = 1'b1;
                w.res_val = 1'b0;
                w.cond    = COND_N_EVEN;
                w.target  = STEP_EMIT;
            end
            STEP_DIV: begin
                w.div_start = 1'b1;
                w.cond      = COND_NEVER;
                w.target    = STEP_IDLE;
            end
            STEP_WAIT: begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_WAIT;
            end
            STEP_BOUND: begin
                w.res_we  = 1'b1;
                w.res_val = 1'b1;
                w.cond    = COND_D_GT_Q;
                w.target  = STEP_EMIT;
            end
            STEP_REM: begin
                w.res_we  = 1'b1;
                w.res_val = 1'b0;
                w.cond    = COND_REM_ZERO;
                w.target  = STEP_EMIT;
            end
            STEP_NEXT: begin
                w.d_inc  = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_DIV;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = STEP_EMIT;
            end
            STEP_DONE: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/tdpt_divider.sv */
// Restoring divider: one quotient bit per cycle, quotient and remainder of two unsigned words.
module tdpt_divider #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0]   shifted;
    logic [W+1:0] diff;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (diff[W+1]) begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/tdpt_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module tdpt_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  tdpt_pkg::flags_t    flags,
    output tdpt_pkg::ctrl_word_t ctrl
);

    import tdpt_pkg::*;

    step_t      pc_reg, pc_next;
    ctrl_word_t word;
    logic       jump;

    assign word = ucode_rom(pc_reg);
    assign ctrl = word;

    // Condition select
    always_comb begin
        case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = flags.no_input;
            COND_N_LT2:    jump = flags.n_lt2;
            COND_N_EQ2:    jump = flags.n_eq2;
            COND_N_EVEN:   jump = flags.n_even;
            COND_DIV_BUSY: jump = flags.div_busy;
            COND_D_GT_Q:   jump = flags.d_gt_q;
            COND_REM_ZERO: jump = flags.rem_zero;
            COND_OUT_FULL: jump = flags.out_full;
            default:       jump = 1'b1;
        endcase
    end

    assign pc_next = jump ? word.target : step_t'(pc_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/trial_division_prime_test_unit.sv */
// Top level of the trial-division prime test unit: datapath, sequencer and divider.
//
// Takes one unsigned value per transaction on the s_ stream and returns one
// verdict (1 = prime) on the m_ stream. Only the low VALUE_WIDTH bits of the
// candidate are tested. Values below two, and even values above two, are
// settled without the divider. An odd value tries each odd divisor from 3
// while the divisor does not exceed the quotient; each try runs the shared
// restoring divider, then the bound, remainder and next-divisor steps of the
// microcode. One item is worked on at a time; the next one is taken as soon
// as the previous verdict sits in the output register, even while that
// register still waits for m_tready.
module trial_division_prime_test_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] candidate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] is_prime, [7:1] zero
);

    import tdpt_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] VAL_THREE = VALUE_WIDTH'(3);

    ctrl_word_t ctrl;
    flags_t     flags;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   res_reg, res_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   out_reg, out_next;

    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic                   load;
    logic                   emit_fire;

    tdpt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tdpt_divider #(
        .W (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctrl.div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Status flags for the sequencer
    always_comb begin
        flags.no_input = !s_tvalid;
        flags.n_lt2    = n_reg < VAL_TWO;
        flags.n_eq2    = n_reg == VAL_TWO;
        flags.n_even   = !n_reg[0];
        flags.div_busy = div_busy;
        flags.d_gt_q   = d_reg > div_quo;
        flags.rem_zero = div_rem == '0;
        flags.out_full = m_tvalid_reg && !m_tready;
    end

    assign s_tready  = ctrl.accept;
    assign load      = ctrl.accept && s_tvalid;
    assign emit_fire = ctrl.emit && !flags.out_full;

    // Datapath next values
    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        res_next = res_reg;
        out_next = out_reg;
        if (load) begin
            n_next = VALUE_WIDTH'(s_tdata);
            d_next = VAL_THREE;
        end else if (ctrl.d_inc) begin
            d_next = d_reg + VAL_TWO;
        end
        if (ctrl.res_we) begin
            res_next = ctrl.res_val;
        end
        if (emit_fire) begin
            out_next = res_reg;
        end
    end

    // Output register valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, out_reg};

    // The divider is only launched when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_start |-> !div_busy)
        else $error("divider started while busy");

    // An emitted verdict is always presented as a valid output transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_tvalid_reg)
        else $error("emitted verdict not presented");

    // A prime verdict is never given for an even value other than two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && res_reg) |-> (n_reg[0] || flags.n_eq2))
        else $error("even value reported prime");

    // Once an item is taken the input side closes, so no two items are taken back to back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

endmodule

/* bench/prime_verdict_checker.sv */
`timescale 1ns / 1ps
// Stream monitor and scoreboard for the prime test unit: predicts each verdict and compares it.
module prime_verdict_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] candidate
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] is_prime, [7:1] zero
    output int          errors,
    output int          pending,
    output int          checked,
    output int          primes
);

    // Verdicts of accepted candidates, oldest first
    bit verdict_q[$];

    // Trial division over odd divisors; d <= n / d keeps the bound free of overflow
    function automatic bit prime_verdict(input logic [31:0] raw);
        longint unsigned n;
        longint unsigned d;
        n = 64'(raw);
        if (VALUE_WIDTH < 64) begin
            n &= (64'd1 << VALUE_WIDTH) - 64'd1;
        end
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Count a fault; only the first ten are shown
    task automatic report_fault(input string msg);
        if (errors < 10) begin
            $display("[%0t] checker: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : watch
        bit want;
        if (!aresetn) begin
            verdict_q.delete();
        end else begin
            // Output first, so a verdict never pairs with a candidate taken in the same cycle
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_fault($sformatf("unexpected verdict transaction, data 0x%02h",
                                           m_tdata));
                end else begin
                    want = verdict_q.pop_front();
                    checked++;
                    if (m_tdata !== {7'b0, want}) begin
                        report_fault($sformatf("verdict %0d: expected 0x%02h, got 0x%02h",
                                               checked, {7'b0, want}, m_tdata));
                    end else if (want) begin
                        primes++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // append the predicted verdict at the tail
                verdict_q = {verdict_q, prime_verdict(s_tdata)};
            end
        end
        pending = verdict_q.size();
    end

endmodule

/* bench/trial_division_prime_test_unit_test.sv */
`timescale 1ns / 1ps
// Top of the prime test unit bench: clock, reset, candidate stimulus, back-pressure and verdict.
module trial_division_prime_test_unit_test;

    localparam int VALUE_WIDTH  = 32;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_PCT     = 19;

    typedef enum int {
        PH_DIRECTED,
        PH_HOLD,
        PH_QUIET,
        PH_RANDOM
    } phase_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] candidate
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [0] is_prime, [7:1] zero

    int     errors;
    int     pending;
    int     checked;
    int     primes;
    int     sent;
    int     cycle_count;
    phase_t phase = PH_DIRECTED;

    // Small values, squares of primes, mid-size primes, and full-width bit patterns
    logic [31:0] corner_values [23] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
        32'd97, 32'd121, 32'd8191, 32'd63001, 32'd65521, 32'd65535, 32'd1000003,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_0001,
        32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    trial_division_prime_test_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    prime_verdict_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (errors),
        .pending (pending),
        .checked (checked),
        .primes  (primes)
    );

    always #1 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, pending);
            $display("trial_division_prime_test_unit_test: done, errors");
            $finish;
        end
    end

    // Random idle cycle, off during the quiet stretch
    function automatic bit idle_now();
        return (phase != PH_QUIET) && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Offer one candidate and wait for its transaction
    task automatic offer_candidate(input logic [31:0] value);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    // Result side: one long hold-off when the stall phase begins, random idling otherwise
    initial begin : receiver
        int  hold_left;
        bit  hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge aclk);
            if (phase == PH_HOLD && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // Input side and verdict
    initial begin : sender
        logic [31:0] value;
        int          pick;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corner values
        foreach (corner_values[i]) begin
            offer_candidate(corner_values[i]);
        end

        // Small candidates against a stalled result side, so the input backs up
        phase = PH_HOLD;
        repeat (10) offer_candidate(32'($urandom_range(255)));

        // Stretch without idling on either side
        phase = PH_QUIET;
        repeat (20) offer_candidate(32'($urandom_range(4095)));

        // Pause until every verdict is back
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);

        // Random mix: mostly short values, a few 16-bit, some full-width with a quick factor
        phase = PH_RANDOM;
        repeat (47) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                value = 32'($urandom_range(4095));
            end else if (pick < 75) begin
                value = 32'($urandom_range(65535));
            end else begin
                value = $urandom;
                // odd full-width values are pulled down to a multiple of three
                if (value[0]) value = value - (value % 3);
            end
            offer_candidate(value);
        end
        s_tvalid <= 1'b0;

        // Drain
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d candidates, %0d verdicts checked, %0d prime", sent, checked,
                 primes);
        $display("including corner values, a stalled result side, a full drain and a no-idle run");
        if (errors == 0 && pending == 0) begin
            $display("trial_division_prime_test_unit_test: done, clean");
        end else begin
            $display("trial_division_prime_test_unit_test: done, errors");
        end
        $finish;
    end

endmodule
